[hw/rtl/tts_pkg.sv]
`default_nettype none
package tts_pkg;

    localparam int COLUMNS      = 80;
    localparam int VISIBLE_ROWS = 25;
    localparam int HISTORY_ROWS = 100;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(HISTORY_ROWS);
    localparam int LINE_W = $clog2(HISTORY_ROWS + 1);
    localparam int ADDR_W = $clog2(HISTORY_ROWS * COLUMNS);
    localparam int POS_W  = $clog2(VISIBLE_ROWS * COLUMNS + 1);

    localparam int PADDR_W = 3;

    localparam logic [15:0] BLANK_CELL   = 16'h0720;
    localparam logic [7:0]  ATTR_RESET   = 8'h07;
    localparam logic [7:0]  CH_NEWLINE   = 8'd10;
    localparam logic [7:0]  CH_BACKSPACE = 8'd8;
    localparam logic [7:0]  CH_SPACE     = 8'h20;

    typedef enum logic [2:0] {
        KIND_PUT   = 3'd0,
        KIND_UP    = 3'd1,
        KIND_DOWN  = 3'd2,
        KIND_CLEAR = 3'd3,
        KIND_READ  = 3'd4
    } t_kind;

    typedef enum logic {
        REG_ATTR = 1'b0
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ROW_ADDR,
        S_FILL,
        S_WRITE,
        S_SHIFT,
        S_SHIFT_ADDR,
        S_BLANK,
        S_SNAP,
        S_READ,
        S_READ_WAIT,
        S_RESULT,
        S_POS
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       wdata;
    } t_mem_req;

    typedef struct packed {
        logic        valid;
        logic [6:0]  cursor_col;
        logic [6:0]  cursor_row;
        logic [6:0]  view_top;
        logic        cursor_shown;
        logic [10:0] cursor_position;
        logic [15:0] cell_value;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/text_terminal_scrollback.sv]
`default_nettype none
// Character terminal with a 100-row scrollback history of 80 16-bit cells. Pulse start
// while busy is low; the result word appears on the o_ ports for exactly one cycle marked
// by o_result_valid and must be taken then, since the receiver cannot stall the block.
// busy stays high from the accept until the strobe cycle, where a new start is taken.
// All history writes and reads share one single-port cell memory. A newline or a backspace
// at column 0 writes no character, and a cell read that lies off the screen, scroll, clear
// and unused kinds leave the memory untouched. The first write into a row after reset or
// clear first fills that row, and a history scroll blanks the new bottom row through the
// same port.
// Rows are tracked by valid bits, so reset and clear need no memory sweep.
module text_terminal_scrollback
    import tts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_kind,
    input  wire logic [7:0]         i_char_code,
    input  wire logic [4:0]         i_view_row,
    input  wire logic [6:0]         i_view_col,
    output logic                    o_result_valid,
    output logic [6:0]              o_cursor_col,
    output logic [6:0]              o_cursor_row,
    output logic [6:0]              o_view_top,
    output logic                    o_cursor_shown,
    output logic [10:0]             o_cursor_position,
    output logic [15:0]             o_cell_value
);

    logic [7:0]  r_attr;
    logic        core_busy;
    logic [15:0] rdata;
    t_mem_req    req;
    t_result     result;
    t_reg        reg_sel;

    assign reg_sel = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && reg_sel == REG_ATTR) begin
            r_attr <= pwdata[7:0];
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ATTR: prdata = {24'd0, r_attr};
            default:  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    tts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .i_view_row  (i_view_row),
        .i_view_col  (i_view_col),
        .i_attr      (r_attr),
        .i_rdata     (rdata),
        .o_req       (req),
        .o_busy      (core_busy),
        .o_result    (result)
    );

    tts_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    assign busy              = core_busy;
    assign o_result_valid    = result.valid;
    assign o_cursor_col      = result.cursor_col;
    assign o_cursor_row      = result.cursor_row;
    assign o_view_top        = result.view_top;
    assign o_cursor_shown    = result.cursor_shown;
    assign o_cursor_position = result.cursor_position;
    assign o_cell_value      = result.cell_value;

endmodule
`default_nettype wire

[hw/rtl/tts_cell_ram.sv]
`default_nettype none
module tts_cell_ram
    import tts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mem_req    i_req,
    output logic [15:0]      o_rdata
);

    logic [15:0] r_mem [HISTORY_ROWS*COLUMNS];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/tts_core.sv]
`default_nettype none
module tts_core
    import tts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [2:0]  i_kind,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [4:0]  i_view_row,
    input  wire logic [6:0]  i_view_col,
    input  wire logic [7:0]  i_attr,
    input  wire logic [15:0] i_rdata,
    output t_mem_req         o_req,
    output logic             o_busy,
    output t_result          o_result
);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [LINE_W-1:0] LINE_END  = LINE_W'(HISTORY_ROWS);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(HISTORY_ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(HISTORY_ROWS - 1);
    localparam logic [LINE_W-1:0] VIS_ROWS  = LINE_W'(VISIBLE_ROWS);
    localparam logic [LINE_W-1:0] VIS_LESS1 = LINE_W'(VISIBLE_ROWS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [POS_W-1:0]  COLS_P    = POS_W'(COLUMNS);

    function automatic logic [ROW_W-1:0] phys_row(input logic [LINE_W:0] lr,
                                                  input logic [ROW_W-1:0] base);
        logic [LINE_W:0] sum;
        begin
            sum = lr + (LINE_W+1)'(base);
            if (sum >= (LINE_W+1)'(HISTORY_ROWS)) begin
                sum = sum - (LINE_W+1)'(HISTORY_ROWS);
            end
            return ROW_W'(sum);
        end
    endfunction

    t_state r_state, n_state;

    t_kind              r_kind;
    logic [7:0]         r_char;
    logic [4:0]         r_vrow;
    logic [6:0]         r_vcol;
    logic [COL_W-1:0]   r_col;
    logic [LINE_W-1:0]  r_line;
    logic [LINE_W-1:0]  r_view;
    logic [ROW_W-1:0]   r_base;
    logic [ROW_W-1:0]   r_row_sel;
    logic [ADDR_W-1:0]  r_row_base;
    logic [COL_W-1:0]   r_cnt;
    logic [COL_W-1:0]   r_wcol;
    logic [7:0]         r_wchar;
    logic [HISTORY_ROWS-1:0] r_valid;
    logic [LINE_W-1:0]  r_rel;
    logic               r_shown;
    logic [15:0]        r_cell;
    t_result            r_result;

    logic [LINE_W-1:0]  snap;
    logic [LINE_W:0]    read_line;
    logic               read_ok;
    logic               is_nl;
    logic               is_bs;
    logic               fill_last;

    assign snap      = (r_line >= VIS_ROWS) ? r_line - VIS_LESS1 : '0;
    assign read_line = (LINE_W+1)'(r_view) + (LINE_W+1)'(r_vrow);
    assign read_ok   = (32'(r_vrow) < VISIBLE_ROWS) && (32'(r_vcol) < COLUMNS)
                       && (read_line < (LINE_W+1)'(HISTORY_ROWS));
    assign is_nl     = (r_char == CH_NEWLINE);
    assign is_bs     = (r_char == CH_BACKSPACE);
    assign fill_last = (r_cnt == COL_LAST);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_kind)
                    KIND_PUT: begin
                        if (is_nl) n_state = S_SHIFT;
                        else if (is_bs && r_col == '0) n_state = S_SNAP;
                        else n_state = S_ROW_ADDR;
                    end
                    KIND_READ: n_state = read_ok ? S_ROW_ADDR : S_RESULT;
                    default:   n_state = S_RESULT;
                endcase
            end
            S_ROW_ADDR: begin
                if (r_kind == KIND_READ) n_state = S_READ;
                else if (r_valid[r_row_sel]) n_state = S_WRITE;
                else n_state = S_FILL;
            end
            S_FILL:       if (fill_last) n_state = S_WRITE;
            S_WRITE:      n_state = S_SHIFT;
            S_SHIFT:      n_state = (r_line == LINE_END) ? S_SHIFT_ADDR : S_SNAP;
            S_SHIFT_ADDR: n_state = S_BLANK;
            S_BLANK:      if (fill_last) n_state = S_SNAP;
            S_SNAP:       n_state = S_RESULT;
            S_READ:       n_state = S_READ_WAIT;
            S_READ_WAIT:  n_state = S_RESULT;
            S_RESULT:     n_state = S_POS;
            S_POS:        n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // memory port and status
    always_comb begin
        o_req.we    = 1'b0;
        o_req.addr  = r_row_base + ADDR_W'(r_wcol);
        o_req.wdata = {i_attr, r_wchar};
        case (r_state)
            S_FILL: begin
                o_req.we    = 1'b1;
                o_req.addr  = r_row_base + ADDR_W'(r_cnt);
                o_req.wdata = BLANK_CELL;
            end
            S_BLANK: begin
                o_req.we    = 1'b1;
                o_req.addr  = r_row_base + ADDR_W'(r_cnt);
                o_req.wdata = {i_attr, CH_SPACE};
            end
            S_WRITE: o_req.we = 1'b1;
            default: o_req.we = 1'b0;
        endcase
        o_busy = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_col          <= '0;
            r_line         <= '0;
            r_view         <= '0;
            r_base         <= '0;
            r_valid        <= '0;
            r_result.valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result.valid <= (r_state == S_POS);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind <= t_kind'(i_kind);
                        r_char <= i_char_code;
                        r_vrow <= i_view_row;
                        r_vcol <= i_view_col;
                    end
                end
                S_DECODE: begin
                    r_cell <= '0;
                    case (r_kind)
                        KIND_PUT: begin
                            r_row_sel <= phys_row((LINE_W+1)'(r_line), r_base);
                            r_wchar   <= is_bs ? CH_SPACE : r_char;
                            r_wcol    <= is_bs ? r_col - 1'b1 : r_col;
                            if (is_nl) begin
                                r_col  <= '0;
                                r_line <= r_line + 1'b1;
                            end
                        end
                        KIND_UP: begin
                            if (r_view != '0) r_view <= r_view - 1'b1;
                        end
                        KIND_DOWN: begin
                            if (r_view < snap) r_view <= r_view + 1'b1;
                        end
                        KIND_CLEAR: begin
                            r_valid <= '0;
                            r_col   <= '0;
                            r_line  <= '0;
                            r_view  <= '0;
                        end
                        KIND_READ: begin
                            r_row_sel <= phys_row(read_line, r_base);
                            r_wcol    <= COL_W'(r_vcol);
                        end
                        default: ;
                    endcase
                end
                S_ROW_ADDR, S_SHIFT_ADDR: begin
                    r_row_base <= ADDR_W'(r_row_sel) * COLS_A;
                    r_cnt      <= '0;
                end
                S_FILL, S_BLANK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (fill_last) r_valid[r_row_sel] <= 1'b1;
                end
                S_WRITE: begin
                    if (is_bs) begin
                        r_col <= r_wcol;
                    end else if (r_col == COL_LAST) begin
                        r_col  <= '0;
                        r_line <= r_line + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (r_line == LINE_END) begin
                        // ring rotate: old top row becomes the new bottom row
                        r_line    <= LINE_LAST;
                        r_row_sel <= r_base;
                        r_base    <= (r_base == ROW_LAST) ? '0 : r_base + 1'b1;
                    end
                end
                S_SNAP: r_view <= snap;
                S_READ_WAIT: r_cell <= r_valid[r_row_sel] ? i_rdata : BLANK_CELL;
                S_RESULT: begin
                    r_rel   <= r_line - r_view;
                    r_shown <= (r_line >= r_view) && ((r_line - r_view) < VIS_ROWS);
                end
                S_POS: begin
                    r_result.cursor_col   <= 7'(r_col);
                    r_result.cursor_row   <= 7'(r_line);
                    r_result.view_top     <= 7'(r_view);
                    r_result.cursor_shown <= r_shown;
                    r_result.cursor_position <= r_shown
                        ? 11'(POS_W'(r_rel) * COLS_P + POS_W'(r_col)) : '0;
                    r_result.cell_value   <= r_cell;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_result = r_result;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result.valid |=> !r_result.valid)
        else $error("result strobe longer than one cycle");

    a_strobe_after_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |=> (r_result.valid && r_state == S_IDLE))
        else $error("result not issued after position step");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req.we |-> (r_state == S_FILL || r_state == S_WRITE || r_state == S_BLANK))
        else $error("memory write outside a write state");

    a_idle_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_line < LINE_END && r_view <= snap))
        else $error("cursor line or view out of range while idle");

endmodule
`default_nettype wire
